// ===== hw/rtl/spn_pkg.sv =====
// ----------------------------------------------------------------------------
// spn_pkg: shared types and constants for the step pattern note scheduler
// widths, register indexes, divider request/response and tick scaling
// ----------------------------------------------------------------------------
package spn_pkg;

  localparam int TICK_W     = 17;
  localparam int BASE_TICKS = 480;
  localparam int MAX_SUBDIV = 16;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = 4;
  localparam int NOTE_W     = 8;
  localparam int BEAT_W     = 6;
  localparam int MODE_W     = 3;
  localparam int BT_W       = 7;
  localparam int NT_W       = 8;
  localparam int WRAP_W     = 9;
  localparam int DUR_W      = 11;
  localparam int DIVD_W     = 11;
  localparam int DIVS_W     = 8;
  localparam int DIV_CNT_W  = $clog2(DIVD_W);
  localparam int SCALE_W    = 21;

  // configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BEATS = 2'd1;
  localparam logic [1:0] REG_NOTES = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIVS_W-1:0] remainder;
  } div_rsp_t;

  // x * BASE_TICKS * 8 >> sh, masked to tick width
  function automatic logic [TICK_W-1:0] tick_scale(input logic [WRAP_W-1:0] x,
                                                   input logic [2:0] sh);
    logic [SCALE_W-1:0] prod;
    prod = SCALE_W'(x) * SCALE_W'(BASE_TICKS * 8);
    return TICK_W'(prod >> sh);
  endfunction

  // tuplet modes: x4, x2, x1, x1/2 of the base beat
  function automatic logic [2:0] tuplet_shift(input logic [MODE_W-1:0] mode);
    return {1'b0, mode[2:1]} + 3'd1;
  endfunction

  // straight modes: x1, x1/2, x1/4, x1/8 of the base beat
  function automatic logic [2:0] straight_shift(input logic [MODE_W-1:0] mode);
    return {1'b0, mode[2:1]} + 3'd3;
  endfunction

endpackage

// ===== hw/rtl/step_pattern_note_scheduler.sv =====
// ----------------------------------------------------------------------------
// step_pattern_note_scheduler: beat subdivision to note tick scheduler
// takes one beat with its note count, emits one item per note with start and
// wrapped end tick, running note index and beat index
// ----------------------------------------------------------------------------
// sequencing: a tuplet beat is divided for the note duration and, unless
//   beat_total is zero, for beat mod beat_total, then prepared; a straight beat
//   is divided for its end note index unless note_total is zero; each division
//   is a pass of one 11-step serial divider, then one note per cycle while the
//   output is taken
// a beat of zero notes is taken without leaving idle and steps the beat counter;
//   no new beat is taken until the last note is in the output register
// reset: counters clear, registers return to mode 5, one beat, one note
// ----------------------------------------------------------------------------
module step_pattern_note_scheduler
  import spn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // beat input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] subdivisions, [7:5] zero
  input  logic        s_tuser,   // [0] restart
  // note output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [16:0] start_tick, [33:17] end_tick,
                                 // [41:34] note_number, [47:42] beat_number
  output logic        m_tlast,   // last_of_beat
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DIV_DUR = 5'b00010,
    ST_DIV_MOD = 5'b00100,
    ST_PREP    = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [MODE_W-1:0] subdivision_mode;
  logic [BT_W-1:0]   beat_total;
  logic [NT_W-1:0]   note_total;

  // pattern counters
  logic [BEAT_W-1:0] beat_counter;
  logic [NOTE_W-1:0] note_counter;

  // per-beat working registers
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  note_idx;
  logic              tuplet;
  logic [DUR_W-1:0]  dur;
  logic [WRAP_W-1:0] wrap_idx;   // tuplet: beat mod beat_total, straight: end note index
  logic [TICK_W-1:0] start_acc;
  logic [TICK_W-1:0] end_base;
  logic [TICK_W-1:0] end_alt;
  logic [DUR_W-1:0]  end_off;

  // divider request fields, start from the sequencer, operands from the datapath
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req = '{start: div_start, dividend: div_dividend, divisor: div_divisor};

  // item handshakes
  logic s_fire;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // mode-derived scaling
  logic [2:0]        tsh;
  logic [2:0]        ssh;
  logic [DUR_W-1:0]  tpb;
  logic [DUR_W-1:0]  straight_dur;
  assign tsh          = tuplet_shift(subdivision_mode);
  assign ssh          = straight_shift(subdivision_mode);
  assign tpb          = DUR_W'(tick_scale(WRAP_W'(1), tsh));
  assign straight_dur = DUR_W'(tick_scale(WRAP_W'(1), ssh));

  // input item decode: count saturates, restart clears the counters first
  logic [CNT_W-1:0]  sat_count;
  logic [BEAT_W-1:0] bc_in;
  logic [NOTE_W-1:0] nc_in;
  assign sat_count = (s_tdata[4:0] > CNT_W'(MAX_SUBDIV)) ? CNT_W'(MAX_SUBDIV)
                                                         : s_tdata[4:0];
  assign bc_in     = s_tuser ? '0 : beat_counter;
  assign nc_in     = s_tuser ? '0 : note_counter;

  // next wrapped beat, used when the last tuplet note ends on the beat line
  logic [WRAP_W-1:0] wrap_beat_next;
  assign wrap_beat_next = ((beat_total != '0) && (wrap_idx + WRAP_W'(1) == WRAP_W'(beat_total)))
                          ? '0 : wrap_idx + WRAP_W'(1);

  // next end note index for straight modes, restarting when the note index wraps
  logic [WRAP_W-1:0] wrap_note_next;
  always_comb begin
    priority if (note_counter == '1) begin
      wrap_note_next = (note_total == NT_W'(1)) ? '0 : WRAP_W'(1);
    end else if ((note_total != '0) && (wrap_idx + WRAP_W'(1) == WRAP_W'(note_total))) begin
      wrap_note_next = '0;
    end else begin
      wrap_note_next = wrap_idx + WRAP_W'(1);
    end
  end

  // note values presented to the output register
  logic              out_free;
  logic              emit_fire;
  logic              emit_last;
  logic [TICK_W-1:0] note_start;
  logic [TICK_W-1:0] note_end;
  assign out_free  = !m_tvalid || m_tready;
  assign emit_fire = (state == ST_EMIT) && out_free;
  assign emit_last = (CNT_W'(note_idx) + CNT_W'(1)) == count;

  always_comb begin
    if (tuplet) begin
      note_start = start_acc;
      if ((beat_total != '0) && (end_off == tpb)) begin
        note_end = end_alt;
      end else begin
        note_end = end_base + TICK_W'(end_off);
      end
    end else begin
      note_start = tick_scale(WRAP_W'(note_counter), ssh);
      note_end   = tick_scale(wrap_idx, ssh);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      subdivision_mode <= MODE_W'(5);
      beat_total       <= BT_W'(1);
      note_total       <= NT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:  subdivision_mode <= cfg_data[MODE_W-1:0];
        REG_BEATS: beat_total       <= cfg_data[BT_W-1:0];
        REG_NOTES: note_total       <= cfg_data[NT_W-1:0];
        default:   ;
      endcase
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      beat_counter <= '0;
      note_counter <= '0;
      div_start    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            note_counter <= nc_in;
            if (sat_count == '0) begin
              // no notes, the beat still counts
              beat_counter <= bc_in + BEAT_W'(1);
            end else begin
              beat_counter <= bc_in;
              if (subdivision_mode[0]) begin
                div_start <= 1'b1;
                state     <= ST_DIV_DUR;
              end else if (note_total != '0) begin
                div_start <= 1'b1;
                state     <= ST_DIV_MOD;
              end else begin
                state <= ST_EMIT;
              end
            end
          end
        end
        ST_DIV_DUR: begin
          if (div_rsp.done) begin
            if (beat_total != '0) begin
              div_start <= 1'b1;
              state     <= ST_DIV_MOD;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_DIV_MOD: begin
          if (div_rsp.done) begin
            state <= tuplet ? ST_PREP : ST_EMIT;
          end
        end
        ST_PREP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            note_counter <= note_counter + NOTE_W'(1);
            if (emit_last) begin
              beat_counter <= beat_counter + BEAT_W'(1);
              state        <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-beat datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        count    <= sat_count;
        note_idx <= '0;
        tuplet   <= subdivision_mode[0];
        if (subdivision_mode[0]) begin
          div_dividend <= DIVD_W'(tpb);
          div_divisor  <= DIVS_W'(sat_count);
        end else begin
          dur          <= straight_dur;
          div_dividend <= DIVD_W'(nc_in) + DIVD_W'(1);
          div_divisor  <= note_total;
          wrap_idx     <= WRAP_W'(nc_in) + WRAP_W'(1);
        end
      end
      ST_DIV_DUR: begin
        if (div_rsp.done) begin
          dur          <= div_rsp.quotient;
          div_dividend <= DIVD_W'(beat_counter);
          div_divisor  <= DIVS_W'(beat_total);
          wrap_idx     <= WRAP_W'(beat_counter);
        end
      end
      ST_DIV_MOD: begin
        if (div_rsp.done) begin
          wrap_idx <= WRAP_W'(div_rsp.remainder);
        end
      end
      ST_PREP: begin
        start_acc <= tick_scale(WRAP_W'(beat_counter), tsh);
        end_base  <= tick_scale(wrap_idx, tsh);
        end_alt   <= tick_scale(wrap_beat_next, tsh);
        end_off   <= dur;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          note_idx  <= note_idx + IDX_W'(1);
          start_acc <= start_acc + TICK_W'(dur);
          end_off   <= end_off + dur;
          if (!tuplet) begin
            wrap_idx <= wrap_note_next;
          end
        end
      end
      default: ;
    endcase
  end

  // output register, refilled in the cycle it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= {beat_counter, note_counter, note_end, note_start};
      m_tlast <= emit_last;
    end
  end

  spn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // note index never runs past the beat's count
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((CNT_W'(note_idx) < count) && (count != '0)))
    else $error("note index past beat count");

  // divider results only arrive while the sequencer waits for them
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> ((state == ST_DIV_DUR) || (state == ST_DIV_MOD)))
    else $error("divider done outside a divide state");

  // the beat counter steps once the last note of a beat is sent
  a_beat_advance: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && emit_last) |=> (beat_counter == BEAT_W'($past(beat_counter) + 1'b1)))
    else $error("beat counter did not advance after last note");

  // a division start is never followed directly by a done pulse
  a_div_single: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

endmodule

// ===== hw/rtl/spn_div.sv =====
// ----------------------------------------------------------------------------
// spn_div: shared restoring divider
// one quotient bit per cycle, quotient and remainder valid on done
// ----------------------------------------------------------------------------
module spn_div
  import spn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] step;
  logic [DIVS_W-1:0]    rem;
  logic [DIVD_W-1:0]    quo;
  logic [DIVS_W-1:0]    divisor;
  logic [DIVS_W:0]      trial;
  logic                 fits;

  assign trial = {rem, quo[DIVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + DIV_CNT_W'(1);
        if (step == DIV_CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift dividend out, quotient in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIVS_W-1:0];
      end
      quo <= {quo[DIVD_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== tb/step_pattern_note_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// step_pattern_note_scheduler_tb: self-checking bench for the note scheduler
// feeds beats with random subdivision counts under every subdivision mode and
// a spread of pattern lengths, predicts each note's ticks and indexes in a
// small timeline model and checks every note item in order, with random
// stalls on both streams
// ----------------------------------------------------------------------------
module step_pattern_note_scheduler_tb
  import spn_pkg::*;
();

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 60;   // covers the longest beat with no notes in flight
  localparam int PHASES         = 12;
  localparam int RAND_PER_PHASE = 20;
  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped register index

  typedef enum logic [MODE_W-1:0] {
    MODE_4TH, MODE_4TH_TUP, MODE_8TH, MODE_8TH_TUP,
    MODE_16TH, MODE_16TH_TUP, MODE_32ND, MODE_32ND_TUP
  } subdiv_mode_t;

  typedef struct {
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] end_tick;
    logic [NOTE_W-1:0] note_number;
    logic [BEAT_W-1:0] beat_number;
    logic              last_of_beat;
  } note_t;

  // timeline of the pattern: register copies, beat and note counters, and the
  // notes still owed by the block, oldest first
  class note_timeline;
    logic [MODE_W-1:0] mode;
    logic [BT_W-1:0]   beat_total;
    logic [NT_W-1:0]   note_total;
    logic [BEAT_W-1:0] beat_cnt;
    logic [NOTE_W-1:0] note_cnt;
    note_t             pending_notes[$];
    int                errors;
    int                beats_taken;
    int                notes_checked;

    function new();
      mode          = MODE_16TH_TUP;
      beat_total    = 1;
      note_total    = 1;
      beat_cnt      = '0;
      note_cnt      = '0;
      errors        = 0;
      beats_taken   = 0;
      notes_checked = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
        REG_MODE:  mode = val[MODE_W-1:0];
        REG_BEATS: beat_total = val[BT_W-1:0];
        REG_NOTES: note_total = val[NT_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted beat: queue the notes it schedules
    function void take_beat(input logic [CNT_W-1:0] subdivisions, input logic restart);
      int unsigned count;
      int unsigned beat_ticks;
      int unsigned dur;
      int unsigned seq_len;
      int unsigned start;
      int unsigned stop;
      note_t       n;
      beats_taken++;
      if (restart) begin
        beat_cnt = '0;
        note_cnt = '0;
      end
      count = subdivisions;
      if (count > MAX_SUBDIV) count = MAX_SUBDIV;
      if (mode[0]) begin
        case (mode)
          MODE_4TH_TUP:  beat_ticks = BASE_TICKS * 4;
          MODE_8TH_TUP:  beat_ticks = BASE_TICKS * 2;
          MODE_16TH_TUP: beat_ticks = BASE_TICKS;
          default:       beat_ticks = BASE_TICKS / 2;
        endcase
        seq_len = beat_ticks * beat_total;
        dur     = (count != 0) ? beat_ticks / count : 0;
      end else begin
        beat_ticks = 0;
        dur        = BASE_TICKS >> mode[2:1];
        seq_len    = dur * note_total;
      end
      for (int unsigned i = 0; i < count; i++) begin
        // tuplets are laid out inside the beat, straight notes back to back
        if (mode[0]) start = beat_cnt * beat_ticks + dur * i;
        else start = note_cnt * dur;
        stop = start + dur;
        if (seq_len != 0) stop = stop % seq_len;
        n.start_tick   = start[TICK_W-1:0];
        n.end_tick     = stop[TICK_W-1:0];
        n.note_number  = note_cnt;
        n.beat_number  = beat_cnt;
        n.last_of_beat = (i + 1 == count);
        pending_notes.insert(pending_notes.size(), n);
        note_cnt = note_cnt + 1'b1;
      end
      beat_cnt = beat_cnt + 1'b1;  // six bits wrap after 64 beats
    endfunction

    function void check_note(input note_t got);
      note_t want;
      if (pending_notes.size() == 0) begin
        $error("unexpected note item: start_tick %0d note_number %0d",
               got.start_tick, got.note_number);
        errors++;
        return;
      end
      want = pending_notes.pop_front();
      notes_checked++;
      if (got.start_tick !== want.start_tick) begin
        $error("start_tick: expected %0d, got %0d", want.start_tick, got.start_tick);
        errors++;
      end
      if (got.end_tick !== want.end_tick) begin
        $error("end_tick: expected %0d, got %0d", want.end_tick, got.end_tick);
        errors++;
      end
      if (got.note_number !== want.note_number) begin
        $error("note_number: expected %0d, got %0d", want.note_number, got.note_number);
        errors++;
      end
      if (got.beat_number !== want.beat_number) begin
        $error("beat_number: expected %0d, got %0d", want.beat_number, got.beat_number);
        errors++;
      end
      if (got.last_of_beat !== want.last_of_beat) begin
        $error("last_of_beat: expected %0d, got %0d", want.last_of_beat, got.last_of_beat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  note_timeline timeline = new();
  int           cycles = 0;
  int           rx_hold = 0;
  bit           steady = 1'b0;   // no random gaps drawn on either stream while set
  int           settings_used = 0;

  // pattern lengths tried with each mode in the directed phases
  logic [7:0] beats_tab [8] = '{8'd1, 8'd127, 8'd0, 8'd64, 8'h80, 8'd0, 8'd3, 8'd64};
  logic [7:0] notes_tab [8] = '{8'd255, 8'd0, 8'd0, 8'd1, 8'd16, 8'd128, 8'd16, 8'd200};

  step_pattern_note_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(15, 50);
    if (r < 8) return 0;
    return $urandom_range(1, 3);
  endfunction

  // note stream back-pressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      rx_hold  <= pick_gap();
    end
  end

  // every note item taken is checked against the oldest owed note
  always @(posedge clk) begin : note_monitor
    note_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.start_tick   = m_tdata[16:0];
      got.end_tick     = m_tdata[33:17];
      got.note_number  = m_tdata[41:34];
      got.beat_number  = m_tdata[47:42];
      got.last_of_beat = m_tlast;
      timeline.check_note(got);
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("step_pattern_note_scheduler_tb: FAIL");
      $finish;
    end
  end

  // one beat item, held until taken; valid stays up across back-to-back items
  task automatic send_beat(input logic [CNT_W-1:0] sub, input logic restart, input int gap);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, sub};
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    timeline.take_beat(sub, restart);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timeline.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every owed note come out, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (timeline.pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0]       mode_val;
    logic [7:0]       beats_val;
    logic [7:0]       notes_val;
    logic [CNT_W-1:0] sub;
    logic             restart;
    int               r;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats at the reset settings: restart, full beat, empty beat,
    // a saturating count, empty beat with restart, uneven tuplet split
    send_beat(5'd1, 1'b1, 0);
    send_beat(5'd16, 1'b0, 0);
    send_beat(5'd0, 1'b0, 1);
    send_beat(5'd31, 1'b0, 0);
    send_beat(5'd0, 1'b1, 2);
    send_beat(5'd7, 1'b0, 0);
    drain();
    write_reg(REG_SPARE, 8'hA5);  // unmapped index must leave settings alone

    for (int phase = 0; phase < PHASES; phase++) begin
      // directed phases walk all modes with extreme pattern lengths,
      // the rest draw random settings including the unused high bits
      if (phase < 8) begin
        mode_val  = 8'(phase);
        beats_val = beats_tab[phase];
        notes_val = notes_tab[phase];
      end else begin
        mode_val  = 8'($urandom_range(0, 255));
        beats_val = 8'($urandom_range(0, 255));
        notes_val = 8'($urandom_range(0, 255));
      end
      write_reg(REG_MODE, mode_val);
      write_reg(REG_BEATS, beats_val);
      write_reg(REG_NOTES, notes_val);
      settings_used++;
      steady = (phase % 4 == 1);

      if (phase < 8) begin
        send_beat(5'd16, 1'b1, 0);
        send_beat(CNT_W'(phase + 3), 1'b0, 0);
      end

      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // well-formed runs of beats; restarts are rare so counters roll over
        r = $urandom_range(0, 99);
        if (r < 6) sub = CNT_W'($urandom_range(17, 31));
        else if (r < 12) sub = '0;
        else sub = CNT_W'($urandom_range(1, 16));
        restart = (k == 0 && phase % 4 == 0) || ($urandom_range(0, 79) == 0);
        // in phase 3 and some random phases the sender holds off once mid-phase until the block has caught up
        if (k == RAND_PER_PHASE / 2 && (phase == 3 || $urandom_range(0, 3) == 0)) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (timeline.pending_notes.size() != 0) @(posedge clk);
        end
        send_beat(sub, restart, steady ? 0 : pick_gap());
      end
      drain();
    end

    if (timeline.pending_notes.size() != 0) begin
      $error("%0d note items never arrived", timeline.pending_notes.size());
      timeline.errors++;
    end
    $display("run: %0d beats sent, %0d notes checked over %0d register settings",
             timeline.beats_taken, timeline.notes_checked, settings_used);
    $display("all eight subdivision modes, zero and full pattern lengths, counter rollover");
    if (timeline.errors == 0) begin
      $display("step_pattern_note_scheduler_tb: PASS");
    end else begin
      $display("step_pattern_note_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule
